// ----- hw/rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
// spq_pkg: shared types, constants and the step ROM of the servo pattern sequencer.
// Depends on nothing; used by every module of the block.
package spq_pkg;

  localparam int NUM_MOODS  = 7;
  localparam int MAX_STEPS  = 8;
  localparam int DWELL_BITS = 16;

  localparam int STEP_W = $clog2(MAX_STEPS);
  localparam int LEN_W  = $clog2(MAX_STEPS);
  localparam int ROM_AW = 5;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_MOOD   = 2'd1,
    REQ_ENABLE = 2'd2,
    REQ_WIGGLE = 2'd3
  } req_t;

  localparam logic [2:0] IDLE_MOOD     = 3'd1;
  localparam logic [2:0] QUIET_PATTERN = 3'd7;
  localparam logic [2:0] NO_MOOD       = 3'd7;
  localparam logic [9:0] PARK_TILT     = 10'd800;
  localparam logic [9:0] PARK_SPEED    = 10'd250;
  localparam logic [2:0] MOOD_LIMIT    = 3'(NUM_MOODS);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_STEPS - 1);

  typedef struct packed {
    logic signed [11:0] pan;
    logic [9:0]         tilt;
    logic [9:0]         speed;
    logic [15:0]        dwell;
  } step_t;

  typedef struct packed {
    logic signed [11:0] pan;
    logic [9:0]         tilt;
    logic [9:0]         speed;
    logic               park;
  } move_t;

  function automatic step_t rom_step(input logic [ROM_AW-1:0] idx);
    step_t s;
    case (idx)
      5'd0:  s = '{12'sd0,    10'd780, 10'd200, 16'd10000};
      5'd1:  s = '{12'sd0,    10'd800, 10'd200, 16'd4000};
      5'd2:  s = '{12'sd300,  10'd820, 10'd250, 16'd1500};
      5'd3:  s = '{-12'sd300, 10'd820, 10'd250, 16'd1500};
      5'd4:  s = '{12'sd0,    10'd800, 10'd200, 16'd5000};
      5'd5:  s = '{12'sd0,    10'd850, 10'd200, 16'd900};
      5'd6:  s = '{12'sd0,    10'd750, 10'd200, 16'd900};
      5'd7:  s = '{12'sd0,    10'd800, 10'd200, 16'd3500};
      5'd8:  s = '{12'sd800,  10'd850, 10'd500, 16'd600};
      5'd9:  s = '{-12'sd800, 10'd850, 10'd500, 16'd600};
      5'd10: s = '{12'sd600,  10'd870, 10'd800, 16'd250};
      5'd11: s = '{-12'sd600, 10'd870, 10'd800, 16'd250};
      5'd12: s = '{12'sd600,  10'd750, 10'd800, 16'd250};
      5'd13: s = '{-12'sd600, 10'd750, 10'd800, 16'd250};
      5'd14: s = '{12'sd0,    10'd820, 10'd400, 16'd800};
      5'd15: s = '{12'sd500,  10'd720, 10'd700, 16'd250};
      5'd16: s = '{-12'sd500, 10'd870, 10'd700, 16'd250};
      5'd17: s = '{12'sd500,  10'd870, 10'd700, 16'd250};
      5'd18: s = '{-12'sd500, 10'd720, 10'd700, 16'd250};
      5'd19: s = '{12'sd400,  10'd820, 10'd200, 16'd1200};
      5'd20: s = '{-12'sd400, 10'd820, 10'd200, 16'd1200};
      5'd21: s = '{12'sd0,    10'd800, 10'd200, 16'd60000};
      default: s = '{12'sd0,  10'd0,   10'd0,   16'd0};
    endcase
    return s;
  endfunction

  function automatic logic [ROM_AW-1:0] table_start(input logic [2:0] pat);
    logic [ROM_AW-1:0] r;
    case (pat)
      3'd0: r = 5'd0;
      3'd1: r = 5'd1;
      3'd2: r = 5'd5;
      3'd3: r = 5'd8;
      3'd4: r = 5'd10;
      3'd5: r = 5'd15;
      3'd6: r = 5'd19;
      default: r = 5'd21;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] table_len(input logic [2:0] pat);
    logic [2:0] r;
    case (pat)
      3'd0: r = 3'd1;
      3'd1: r = 3'd4;
      3'd2: r = 3'd3;
      3'd3: r = 3'd2;
      3'd4: r = 3'd5;
      3'd5: r = 3'd4;
      3'd6: r = 3'd2;
      default: r = 3'd1;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/spq_core.sv -----
`timescale 1ns / 1ps
// spq_core: sequencer state and the single-pass decode of one request.
// Depends on spq_pkg (ROM, constants, types).
module spq_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  spq_pkg::req_t       req_type,
  input  logic [2:0]          request_value,
  output logic                res_valid,
  output spq_pkg::move_t      res_move
);

  logic [2:0]                     current_mood_r, current_mood_nxt;
  logic [2:0]                     active_pattern_r, active_pattern_nxt;
  logic [spq_pkg::STEP_W-1:0]     step_index_r, step_index_nxt;
  logic [spq_pkg::DWELL_BITS-1:0] dwell_r, dwell_nxt;
  logic                           running_r, running_nxt;
  logic                           motion_en_r, motion_en_nxt;
  logic                           wiggle_en_r, wiggle_en_nxt;

  logic                           flag;
  logic [spq_pkg::DWELL_BITS-1:0] dwell_dec;
  logic [spq_pkg::LEN_W-1:0]      tbl_len, len_cap;
  logic [spq_pkg::ROM_AW-1:0]     rom_idx;
  spq_pkg::step_t                 step;

  assign flag      = (request_value != 3'd0);
  assign dwell_dec = (dwell_r != '0) ? dwell_r - 1'b1 : dwell_r;
  assign tbl_len   = spq_pkg::LEN_W'(spq_pkg::table_len(active_pattern_r));
  assign len_cap   = (tbl_len > spq_pkg::LEN_LIMIT) ? spq_pkg::LEN_LIMIT : tbl_len;
  assign rom_idx   = spq_pkg::table_start(active_pattern_r)
                   + spq_pkg::ROM_AW'(step_index_r);
  assign step      = spq_pkg::rom_step(rom_idx);

  always_comb begin
    current_mood_nxt   = current_mood_r;
    active_pattern_nxt = active_pattern_r;
    step_index_nxt     = step_index_r;
    dwell_nxt          = dwell_r;
    running_nxt        = running_r;
    motion_en_nxt      = motion_en_r;
    wiggle_en_nxt      = wiggle_en_r;
    res_valid          = 1'b0;
    res_move.pan       = step.pan;
    res_move.tilt      = step.tilt;
    res_move.speed     = step.speed;
    res_move.park      = 1'b0;
    case (req_type)
      spq_pkg::REQ_TICK: begin
        dwell_nxt = dwell_dec;
        if (motion_en_r && running_r && (dwell_dec == '0)) begin
          if (spq_pkg::LEN_W'(step_index_r) >= len_cap) begin
            step_index_nxt = '0;
          end else begin
            res_valid      = 1'b1;
            dwell_nxt      = spq_pkg::DWELL_BITS'(step.dwell);
            step_index_nxt = step_index_r + 1'b1;
          end
        end
      end
      spq_pkg::REQ_MOOD: begin
        if ((request_value < spq_pkg::MOOD_LIMIT) && (request_value != current_mood_r)) begin
          current_mood_nxt   = request_value;
          active_pattern_nxt = ((request_value == spq_pkg::IDLE_MOOD) && !wiggle_en_r) ?
                               spq_pkg::QUIET_PATTERN : request_value;
          step_index_nxt     = '0;
          dwell_nxt          = '0;
          running_nxt        = 1'b1;
        end
      end
      spq_pkg::REQ_ENABLE: begin
        motion_en_nxt = flag;
        if (!flag) begin
          running_nxt    = 1'b0;
          res_valid      = 1'b1;
          res_move.pan   = 12'sd0;
          res_move.tilt  = spq_pkg::PARK_TILT;
          res_move.speed = spq_pkg::PARK_SPEED;
          res_move.park  = 1'b1;
        end else if (current_mood_r < spq_pkg::MOOD_LIMIT) begin
          active_pattern_nxt = ((current_mood_r == spq_pkg::IDLE_MOOD) && !wiggle_en_r) ?
                               spq_pkg::QUIET_PATTERN : current_mood_r;
          step_index_nxt     = '0;
          dwell_nxt          = '0;
          running_nxt        = 1'b1;
        end
      end
      default: begin
        wiggle_en_nxt = flag;
        if (current_mood_r == spq_pkg::IDLE_MOOD) begin
          active_pattern_nxt = flag ? spq_pkg::IDLE_MOOD : spq_pkg::QUIET_PATTERN;
          step_index_nxt     = '0;
          dwell_nxt          = '0;
          running_nxt        = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_mood_r   <= spq_pkg::NO_MOOD;
      active_pattern_r <= 3'd0;
      step_index_r     <= '0;
      dwell_r          <= '0;
      running_r        <= 1'b0;
      motion_en_r      <= 1'b1;
      wiggle_en_r      <= 1'b1;
    end else if (fire) begin
      current_mood_r   <= current_mood_nxt;
      active_pattern_r <= active_pattern_nxt;
      step_index_r     <= step_index_nxt;
      dwell_r          <= dwell_nxt;
      running_r        <= running_nxt;
      motion_en_r      <= motion_en_nxt;
      wiggle_en_r      <= wiggle_en_nxt;
    end
  end

endmodule

// ----- hw/rtl/spq_out_reg.sv -----
`timescale 1ns / 1ps
// spq_out_reg: result register holding one move until the consumer takes it.
// Depends on spq_pkg (move_t).
module spq_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic               res_valid,
  input  spq_pkg::move_t     res_move,
  input  logic               out_ready,
  output logic               out_valid,
  output spq_pkg::move_t     out_move
);

  logic           valid_r, valid_nxt;
  spq_pkg::move_t move_r;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) valid_nxt = 1'b0;
    if (load && res_valid) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      move_r <= res_move;
    end
  end

  assign out_valid = valid_r;
  assign out_move  = move_r;

endmodule

// ----- hw/rtl/servo_pattern_sequencer.sv -----
`timescale 1ns / 1ps
// servo_pattern_sequencer: top level; input register, core and result register.
// Depends on spq_pkg, spq_core and spq_out_reg.
//
//  channel | direction | ports                                   | handshake
//  --------+-----------+-----------------------------------------+-------------------
//  in      | input     | in_req_type, in_request_value           | in_valid/in_ready
//  out     | output    | out_pan_target, out_tilt_target,        | out_valid/out_ready
//          |           | out_servo_speed, out_is_park_move       |
//
// One request per cycle: a request is held in the input register, is
// decoded against the state in a single pass and its move (if any) lands in
// the result register at the edge where it is decoded, which raises out_valid.
// Rate is set by the result register: while it holds an untaken move, the
// next request waits in the input register and in_ready drops.
// Reset (rst_n low, synchronous) empties both registers and restores the
// power-up state: no mood, motion and wiggle enabled, pattern halted.
module servo_pattern_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [2:0]         in_request_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [11:0] out_pan_target,
  output logic [9:0]         out_tilt_target,
  output logic [9:0]         out_servo_speed,
  output logic               out_is_park_move
);

  // input register
  logic          s1_valid_r, s1_valid_nxt;
  spq_pkg::req_t s1_type_r;
  logic [2:0]    s1_value_r;
  logic          s1_fire;
  logic          in_fire;

  logic           res_valid;
  spq_pkg::move_t res_move;
  spq_pkg::move_t out_move;

  // a held request is processed once the result slot is free or being emptied
  assign s1_fire  = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_fire) s1_valid_nxt = 1'b0;
    if (in_fire) s1_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_type_r  <= spq_pkg::req_t'(in_req_type);
      s1_value_r <= in_request_value;
    end
  end

  spq_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (s1_fire),
    .req_type      (s1_type_r),
    .request_value (s1_value_r),
    .res_valid     (res_valid),
    .res_move      (res_move)
  );

  spq_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_fire),
    .res_valid (res_valid),
    .res_move  (res_move),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_move  (out_move)
  );

  assign out_pan_target   = out_move.pan;
  assign out_tilt_target  = out_move.tilt;
  assign out_servo_speed  = out_move.speed;
  assign out_is_park_move = out_move.park;

  // a stalled request must not be lost or altered in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r && $stable(s1_value_r) && $stable(s1_type_r))
    else $error("stalled request lost from input register");

  // a park move always carries the fixed park position
  a_park_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_park_move |->
      out_pan_target == 12'sd0 && out_tilt_target == spq_pkg::PARK_TILT &&
      out_servo_speed == spq_pkg::PARK_SPEED)
    else $error("park move with wrong position");

  // an untaken result is never overwritten by a new decode
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !s1_fire)
    else $error("request decoded while result slot occupied");

  // reset leaves both registers empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !s1_valid_r)
    else $error("registers not empty after reset");

endmodule

// ----- dv/servo_pattern_sequencer_test.sv -----
`timescale 1ns / 1ps
// servo_pattern_sequencer_test: self-checking bench for the servo pattern sequencer.
// Depends on spq_pkg and servo_pattern_sequencer; predicts every move and checks it in order.
module servo_pattern_sequencer_test;

  localparam int HOLD_OFF_CYCLES = 200;  // long receiver hold-off
  localparam int WATCHDOG_LIMIT  = 4000; // cycles with no handshake at all
  localparam int DRAIN_CYCLES    = 10;   // margin after the last move is taken
  localparam int REPORT_LIMIT    = 10;
  localparam int RANDOM_REQUESTS = 580;  // requests in the random phase

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  spq_pkg::req_t      in_req_type;
  logic [2:0]         in_request_value;
  logic               out_valid;
  logic               out_ready;
  logic signed [11:0] out_pan_target;
  logic [9:0]         out_tilt_target;
  logic [9:0]         out_servo_speed;
  logic               out_is_park_move;

  servo_pattern_sequencer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_request_value (in_request_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pan_target   (out_pan_target),
    .out_tilt_target  (out_tilt_target),
    .out_servo_speed  (out_servo_speed),
    .out_is_park_move (out_is_park_move)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Step tables, kept here independently of the package ROM.
  // ---------------------------------------------------------------------------
  int step_pan   [0:21] = '{0, 0, 300, -300, 0, 0, 0, 0, 800, -800,
                            600, -600, 600, -600, 0, 500, -500, 500, -500, 400, -400, 0};
  int step_tilt  [0:21] = '{780, 800, 820, 820, 800, 850, 750, 800, 850, 850,
                            870, 870, 750, 750, 820, 720, 870, 870, 720, 820, 820, 800};
  int step_speed [0:21] = '{200, 200, 250, 250, 200, 200, 200, 200, 500, 500,
                            800, 800, 800, 800, 400, 700, 700, 700, 700, 200, 200, 200};
  int step_dwell [0:21] = '{10000, 4000, 1500, 1500, 5000, 900, 900, 3500, 600, 600,
                            250, 250, 250, 250, 800, 250, 250, 250, 250, 1200, 1200, 60000};
  int pattern_first [0:7] = '{0, 1, 5, 8, 10, 15, 19, 21};
  int pattern_steps [0:7] = '{1, 4, 3, 2, 5, 4, 2, 1};

  // Predicted sequencer state
  logic [2:0]  mood_now;
  logic [2:0]  pattern_now;
  logic [2:0]  step_now;
  int unsigned dwell_left;
  bit          running;
  bit          motion_on;
  bit          wiggle_on;

  spq_pkg::move_t expected_moves[$];

  // Bookkeeping
  int  requests_sent;
  int  ticks_sent;
  int  step_moves;
  int  park_moves;
  int  loop_points;
  int  moves_checked;
  int  fault_count;
  int  hold_offs_done;
  int  idle_cycles;
  bit  idling;
  bit  hold_off_req;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int usable_steps(input logic [2:0] pat);
    int n;
    n = pattern_steps[pat];
    // the last slot of a table is always the loop point
    if (n > spq_pkg::MAX_STEPS - 1)
      n = spq_pkg::MAX_STEPS - 1;
    return n;
  endfunction

  function automatic void restart_pattern();
    // mood 1 with wiggle off plays the quiet table
    if (mood_now == spq_pkg::IDLE_MOOD && !wiggle_on)
      pattern_now = spq_pkg::QUIET_PATTERN;
    else
      pattern_now = mood_now;
    step_now   = 3'd0;
    dwell_left = 0;
    running    = 1'b1;
  endfunction

  function automatic void predict_request(input spq_pkg::req_t kind, input logic [2:0] val);
    bit             flag;
    int             slot;
    spq_pkg::move_t mv;
    flag = (val != 3'd0);
    case (kind)
      spq_pkg::REQ_TICK: begin
        // countdown runs even when halted or disabled
        if (dwell_left != 0)
          dwell_left--;
        if (motion_on && running && dwell_left == 0) begin
          if (step_now >= usable_steps(pattern_now)) begin
            // loop point: back to step 0, no move this tick
            step_now = 3'd0;
            loop_points++;
          end else begin
            slot     = pattern_first[pattern_now] + step_now;
            mv.pan   = 12'(step_pan[slot]);
            mv.tilt  = 10'(step_tilt[slot]);
            mv.speed = 10'(step_speed[slot]);
            mv.park  = 1'b0;
            expected_moves.push_back(mv);
            dwell_left = step_dwell[slot] % (64'd1 << spq_pkg::DWELL_BITS);
            step_now++;
            step_moves++;
          end
        end
      end
      spq_pkg::REQ_MOOD: begin
        // out-of-range mood and a repeat of the current mood are both ignored
        if (val < spq_pkg::NUM_MOODS && val != mood_now) begin
          mood_now = val;
          restart_pattern();
        end
      end
      spq_pkg::REQ_ENABLE: begin
        motion_on = flag;
        if (!flag) begin
          // every disable parks, even when already disabled
          running  = 1'b0;
          mv.pan   = 12'sd0;
          mv.tilt  = spq_pkg::PARK_TILT;
          mv.speed = spq_pkg::PARK_SPEED;
          mv.park  = 1'b1;
          expected_moves.push_back(mv);
          park_moves++;
        end else if (mood_now < spq_pkg::NUM_MOODS) begin
          restart_pattern();
        end
      end
      default: begin
        wiggle_on = flag;
        if (mood_now == spq_pkg::IDLE_MOOD)
          restart_pattern();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Gaps: mostly none or short, now and then a long one
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (!idling)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one request per call, returns at the edge where it was taken.
  // in_valid stays high into the next call when there is no gap, so a
  // back-to-back request never drops valid for a step.
  // ---------------------------------------------------------------------------
  task automatic send_request(input spq_pkg::req_t kind, input logic [2:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= kind;
    in_request_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(kind, val);
    requests_sent++;
    if (kind == spq_pkg::REQ_TICK)
      ticks_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_request(spq_pkg::REQ_TICK, 3'($urandom_range(0, 7)));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver ready: random stalls, plus the long hold-off on demand. The
  // hold-off is timed here so the sender can keep pushing meanwhile.
  // ---------------------------------------------------------------------------
  initial begin : sink_ready
    int stall_left;
    out_ready  = 1'b0;
    stall_left = 0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_offs_done++;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        out_ready <= (stall_left == 0);
      end
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: each taken move against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void note_fault(input string msg);
    fault_count++;
    if (fault_count <= REPORT_LIMIT)
      $display("[%0t] ERROR: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    spq_pkg::move_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_moves.size() == 0) begin
        note_fault($sformatf("unexpected move pan %0d tilt %0d speed %0d park %0b",
                             out_pan_target, out_tilt_target, out_servo_speed,
                             out_is_park_move));
      end else begin
        want = expected_moves.pop_front();
        moves_checked++;
        if (out_pan_target !== want.pan || out_tilt_target !== want.tilt ||
            out_servo_speed !== want.speed || out_is_park_move !== want.park)
          note_fault($sformatf(
            "move %0d: expected pan %0d tilt %0d speed %0d park %0b, got %0d %0d %0d %0b",
            moves_checked, want.pan, want.tilt, want.speed, want.park,
            out_pan_target, out_tilt_target, out_servo_speed, out_is_park_move));
      end
    end
  end

  // Watchdog: too long with neither channel moving means a hang
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] ERROR: no handshake for %0d cycles, %0d moves outstanding",
               $realtime, idle_cycles, expected_moves.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short hand-picked walk through every request kind and corner case.
  task automatic test_directed();
    idling = 1'b0;
    send_request(spq_pkg::REQ_TICK, 3'd0);              // no mood yet: nothing
    send_request(spq_pkg::REQ_MOOD, spq_pkg::NO_MOOD);  // mood 7 is out of range
    send_request(spq_pkg::REQ_ENABLE, 3'd1);   // enable with no mood only sets the flag
    send_request(spq_pkg::REQ_WIGGLE, 3'd0);   // wiggle off, mood not idle
    send_request(spq_pkg::REQ_MOOD, spq_pkg::IDLE_MOOD); // idle mood, wiggle off: quiet
    send_request(spq_pkg::REQ_TICK, 3'd7);     // first quiet step
    send_request(spq_pkg::REQ_MOOD, spq_pkg::IDLE_MOOD); // same mood again: ignored
    send_request(spq_pkg::REQ_WIGGLE, 3'd6);   // nonzero counts as on: restart idle table
    send_request(spq_pkg::REQ_TICK, 3'd0);
    send_request(spq_pkg::REQ_ENABLE, 3'd0);   // park
    send_request(spq_pkg::REQ_ENABLE, 3'd0);   // park again while already disabled
    send_request(spq_pkg::REQ_TICK, 3'd0);     // disabled: nothing
    send_request(spq_pkg::REQ_MOOD, 3'd6);     // mood change while disabled
    send_request(spq_pkg::REQ_TICK, 3'd0);
    send_request(spq_pkg::REQ_ENABLE, 3'd4);   // re-enable restarts mood 6
    send_request(spq_pkg::REQ_TICK, 3'd0);
    send_request(spq_pkg::REQ_ENABLE, 3'd1);   // enable while enabled: restart again
    send_request(spq_pkg::REQ_TICK, 3'd0);
    send_request(spq_pkg::REQ_MOOD, 3'd0);
    send_request(spq_pkg::REQ_TICK, 3'd0);
    send_request(spq_pkg::REQ_MOOD, 3'd5);
    send_request(spq_pkg::REQ_TICK, 3'd0);
    send_request(spq_pkg::REQ_MOOD, 3'd3);
    send_request(spq_pkg::REQ_TICK, 3'd0);
    send_request(spq_pkg::REQ_MOOD, 3'd4);
    send_request(spq_pkg::REQ_TICK, 3'd0);
  endtask

  // Starts each table from step 0 and plays its first step. Dwells run to
  // hundreds of ticks and more, so later steps come from the long bursts of
  // the random test.
  task automatic test_pattern_walk();
    for (int p = 0; p < 8; p++) begin
      idling = $urandom_range(0, 1);
      if (p == spq_pkg::QUIET_PATTERN) begin
        send_request(spq_pkg::REQ_WIGGLE, 3'd0);
        send_request(spq_pkg::REQ_MOOD, spq_pkg::IDLE_MOOD);
      end else begin
        send_request(spq_pkg::REQ_WIGGLE, 3'd1);
        send_request(spq_pkg::REQ_MOOD, 3'(p));
      end
      send_request(spq_pkg::REQ_ENABLE, 3'd1);   // from step 0 whatever went before
      send_ticks(3);
    end
    send_request(spq_pkg::REQ_WIGGLE, 3'd1);
  endtask

  // Mostly mood-then-ticks sequences with random events mixed in, some
  // pure noise. Runs until enough requests have gone through.
  task automatic test_random_sequences();
    int first_req;
    int r;
    int burst;
    idling    = 1'b1;
    first_req = requests_sent;
    while (requests_sent - first_req < RANDOM_REQUESTS) begin
      if (($urandom_range(0, 15)) == 0)
        idling = !idling;                  // stretches without gaps now and then
      r = $urandom_range(0, 9);
      if (r <= 5) begin
        send_request(spq_pkg::REQ_MOOD, 3'($urandom_range(0, 7)));
        if ($urandom_range(0, 2) == 0)
          send_request(spq_pkg::req_t'($urandom_range(spq_pkg::REQ_ENABLE,
                                                       spq_pkg::REQ_WIGGLE)),
                       3'($urandom_range(0, 7)));
        burst = $urandom_range(0, 99);
        if (burst < 95)
          send_ticks($urandom_range(1, 12));
        else
          send_ticks($urandom_range(240, 260)); // past a 250-tick dwell
      end else if (r <= 7) begin
        send_request(spq_pkg::req_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
      end else if (r == 8) begin
        send_request(spq_pkg::REQ_ENABLE, 3'd0);
        send_ticks($urandom_range(1, 5));
        send_request(spq_pkg::REQ_ENABLE, 3'($urandom_range(1, 7)));
        send_ticks($urandom_range(1, 5));
      end else begin
        repeat (5) send_request(spq_pkg::req_t'($urandom_range(0, 3)),
                                3'($urandom_range(0, 7)));
      end
    end
  endtask

  // Receiver holds off for a long stretch while parks keep coming, so the
  // result register fills and in_ready has to drop.
  task automatic test_input_stall();
    idling       = 1'b0;
    hold_off_req = 1'b1;
    repeat (6) begin
      send_request(spq_pkg::REQ_ENABLE, 3'd0);
      send_request(spq_pkg::REQ_TICK, 3'd0);
    end
    send_request(spq_pkg::REQ_ENABLE, 3'd1);
    send_request(spq_pkg::REQ_MOOD, 3'($urandom_range(0, 6)));
    send_ticks(4);
    idling = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Run
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_req_type      = spq_pkg::REQ_TICK;
    in_request_value = 3'd0;
    idling           = 1'b0;
    hold_off_req     = 1'b0;
    idle_cycles      = 0;
    requests_sent    = 0;
    ticks_sent       = 0;
    step_moves       = 0;
    park_moves       = 0;
    loop_points      = 0;
    moves_checked    = 0;
    fault_count      = 0;
    hold_offs_done   = 0;
    // power-up state
    mood_now    = spq_pkg::NO_MOOD;
    pattern_now = 3'd0;
    step_now    = 3'd0;
    dwell_left  = 0;
    running     = 1'b0;
    motion_on   = 1'b1;
    wiggle_on   = 1'b1;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_pattern_walk();
    test_input_stall();
    test_random_sequences();
    test_input_stall();

    in_valid <= 1'b0;
    while (expected_moves.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests (%0d ticks): %0d pattern moves, %0d parks, %0d loop points",
             requests_sent, ticks_sent, step_moves, park_moves, loop_points);
    $display("%0d moves checked, %0d long receiver hold-offs, %0d errors",
             moves_checked, hold_offs_done, fault_count);
    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/spq_pkg.sv
hw/rtl/spq_core.sv
hw/rtl/spq_out_reg.sv
hw/rtl/servo_pattern_sequencer.sv
dv/servo_pattern_sequencer_test.sv
